// File: design/fic_pkg.sv
// shared types and constants for the free interval carve block
`default_nettype none
package fic_pkg;

  localparam int unsigned MAX_SEGMENTS_DEF = 16;
  localparam int unsigned ADDR_BITS_DEF    = 16;

  localparam int unsigned START_W  = 16;
  localparam int unsigned LEN_W    = 17;
  localparam int unsigned TOTAL_W  = 17;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FREE_W   = 5;

  localparam logic [TOTAL_W-1:0] TOTAL_RESET = 17'h10000;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_NOT_FREE = 2'd1,
    STAT_OVERRUN  = 2'd2,
    STAT_FULL     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_SHIFT_DN,
    S_SHIFT_UP,
    S_SPLIT,
    S_RESP
  } state_e;

  typedef struct packed {
    status_e             status;
    logic [FREE_W-1:0]   free_segments;
  } result_t;

endpackage
`default_nettype wire

// File: design/fic_req_if.sv
// request channel carrying the range to allocate
`default_nettype none
interface fic_req_if import fic_pkg::*;;
  logic               valid;
  logic               ready;
  logic [START_W-1:0] alloc_start;
  logic [LEN_W-1:0]   alloc_length;

  modport source (output valid, output alloc_start, output alloc_length, input ready);
  modport sink   (input valid, input alloc_start, input alloc_length, output ready);
endinterface
`default_nettype wire

// File: design/fic_rsp_if.sv
// response channel carrying status and free segment count
`default_nettype none
interface fic_rsp_if import fic_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [FREE_W-1:0]   free_segments;

  modport source (output valid, output status, output free_segments, input ready);
  modport sink   (input valid, input status, input free_segments, output ready);
endinterface
`default_nettype wire

// File: design/fic_cfg_if.sv
// configuration write channel for the total size register
`default_nettype none
interface fic_cfg_if import fic_pkg::*;;
  logic               valid;
  logic               ready;
  logic [TOTAL_W-1:0] total_size;

  modport source (output valid, output total_size, input ready);
  modport sink   (input valid, input total_size, output ready);
endinterface
`default_nettype wire

// File: design/free_interval_carve.sv
// top level of the free interval carve allocator
//
//  channel  dir  payload                        accepted when
//  req_i    in   alloc_start, alloc_length      valid && ready
//  rsp_o    out  status, free_segments          valid && ready
//  cfg_i    in   total_size                     valid (ready held high)
//
// an item scans the segment memory one entry per cycle up to the hit entry h,
// then closes a removed entry by shifting the later entries down, or opens a
// split by shifting them up and writing the high part after the hit entry
// after reset and after each total_size write the table is rebuilt
// a result waits in the output register while the next item is taken in
`default_nettype none
module free_interval_carve import fic_pkg::*; #(
  parameter int unsigned MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int unsigned ADDR_BITS    = ADDR_BITS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  fic_req_if.sink    req_i,
  fic_rsp_if.source  rsp_o,
  fic_cfg_if.sink    cfg_i
);

  logic [TOTAL_W-1:0] total_q, total_d;
  logic               out_valid_q, out_valid_d;
  result_t            out_res_q, out_res_d;

  logic    res_valid;
  logic    res_ready;
  result_t res;

  fic_engine #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .ADDR_BITS    (ADDR_BITS)
  ) u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .init_i         (cfg_i.valid),
    .total_size_i   (total_q),
    .req_valid_i    (req_i.valid),
    .req_ready_o    (req_i.ready),
    .alloc_start_i  (req_i.alloc_start),
    .alloc_length_i (req_i.alloc_length),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res)
  );

  assign cfg_i.ready = 1'b1;
  assign total_d     = cfg_i.valid ? cfg_i.total_size : total_q;

  assign res_ready   = !out_valid_q || rsp_o.ready;
  assign out_valid_d = (res_valid && res_ready) || (out_valid_q && !rsp_o.ready);
  assign out_res_d   = (res_valid && res_ready) ? res : out_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= TOTAL_RESET;
      out_valid_q <= 1'b0;
    end else begin
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_res_q.status;
  assign rsp_o.free_segments = out_res_q.free_segments;

`ifndef SYNTHESIS
  a_one_item_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request taken while another item is in work");

  a_rebuild_blocks_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_i.valid |=> !req_i.ready)
    else $error("request taken during table rebuild");

  a_full_means_max_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.status == STAT_FULL)) |->
      (rsp_o.free_segments == FREE_W'(MAX_SEGMENTS)))
    else $error("table full reported below capacity");
`endif

endmodule
`default_nettype wire

// File: design/fic_engine.sv
// segment table memory and the search, carve and shift sequencer
`default_nettype none
module fic_engine import fic_pkg::*; #(
  parameter int unsigned MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int unsigned ADDR_BITS    = ADDR_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               init_i,
  input  wire logic [TOTAL_W-1:0] total_size_i,
  input  wire logic               req_valid_i,
  output logic                    req_ready_o,
  input  wire logic [START_W-1:0] alloc_start_i,
  input  wire logic [LEN_W-1:0]   alloc_length_i,
  output logic                    res_valid_o,
  input  wire logic               res_ready_i,
  output result_t                 res_o
);

  localparam int unsigned IW = $clog2(MAX_SEGMENTS);
  localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned SW = ADDR_BITS + 1;
  localparam int unsigned MW = ADDR_BITS + SW;
  localparam int unsigned EW = (ADDR_BITS + 2 > 18) ? ADDR_BITS + 2 : 18;
  localparam int unsigned TW = (SW > TOTAL_W) ? SW : TOTAL_W;

  logic [MW-1:0] mem_q [MAX_SEGMENTS];
  logic [MW-1:0] rdata_q;

  logic          we;
  logic [IW-1:0] waddr;
  logic [MW-1:0] wdata;
  logic          re;
  logic [IW-1:0] raddr;

  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [IW-1:0] ptr_q, ptr_d;
  logic [IW-1:0] hit_q, hit_d;
  logic [EW-1:0] start_q, start_d;
  logic [EW-1:0] len_q, len_d;
  logic [EW-1:0] req_end_q, req_end_d;
  logic [EW-1:0] seg_end_q, seg_end_d;
  status_e       status_q, status_d;

  logic [ADDR_BITS-1:0] rd_begin;
  logic [SW-1:0]        rd_size;
  logic [EW-1:0]        rb_ext;
  logic [EW-1:0]        rs_ext;
  logic [EW-1:0]        seg_end;
  logic                 hit_c;
  logic [CW-1:0]        ptr_next_c;
  logic [TW-1:0]        total_ext;
  logic [TW-1:0]        space_lim;
  logic [SW-1:0]        init_size;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  assign rd_begin   = rdata_q[MW-1:SW];
  assign rd_size    = rdata_q[SW-1:0];
  assign rb_ext     = EW'(rd_begin);
  assign rs_ext     = EW'(rd_size);
  assign seg_end    = rb_ext + rs_ext;
  assign hit_c      = (rb_ext <= start_q) && (start_q < seg_end);
  assign ptr_next_c = CW'(ptr_q) + CW'(1);

  assign total_ext = TW'(total_size_i);
  assign space_lim = TW'(1) << ADDR_BITS;
  assign init_size = (total_ext > space_lim) ? space_lim[SW-1:0] : total_ext[SW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q     <= ptr_d;
    hit_q     <= hit_d;
    start_q   <= start_d;
    len_q     <= len_d;
    req_end_q <= req_end_d;
    seg_end_q <= seg_end_d;
    status_q  <= status_d;
  end

  // reads always run ahead of writes during a shift, so no entry is read and written together
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    hit_d       = hit_q;
    start_d     = start_q;
    len_d       = len_q;
    req_end_d   = req_end_q;
    seg_end_d   = seg_end_q;
    status_d    = status_q;
    we          = 1'b0;
    waddr       = '0;
    wdata       = '0;
    re          = 1'b0;
    raddr       = '0;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;

    case (state_q)
      S_INIT: begin
        we      = 1'b1;
        waddr   = '0;
        wdata   = {{ADDR_BITS{1'b0}}, init_size};
        count_d = (init_size != '0) ? CW'(1) : '0;
        state_d = S_IDLE;
      end

      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          start_d   = EW'(alloc_start_i);
          len_d     = EW'(alloc_length_i);
          req_end_d = EW'(alloc_start_i) + EW'(alloc_length_i);
          if (count_q == '0) begin
            status_d = STAT_NOT_FREE;
            state_d  = S_RESP;
          end else begin
            re      = 1'b1;
            raddr   = '0;
            ptr_d   = '0;
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (!hit_c) begin
          // table is address ordered: a later begin past the start ends the search
          if ((rb_ext > start_q) || (ptr_next_c >= count_q)) begin
            status_d = STAT_NOT_FREE;
            state_d  = S_RESP;
          end else begin
            re    = 1'b1;
            raddr = ptr_q + IW'(1);
            ptr_d = ptr_q + IW'(1);
          end
        end else begin
          hit_d     = ptr_q;
          seg_end_d = seg_end;
          status_d  = STAT_OK;
          state_d   = S_RESP;
          if (req_end_q > seg_end) begin
            status_d = STAT_OVERRUN;
          end else if (len_q == '0) begin
            status_d = STAT_OK;
          end else if (start_q == rb_ext) begin
            if (len_q == rs_ext) begin
              if (ptr_next_c < count_q) begin
                re      = 1'b1;
                raddr   = ptr_q + IW'(1);
                ptr_d   = ptr_q + IW'(1);
                state_d = S_SHIFT_DN;
              end else begin
                count_d = count_q - CW'(1);
              end
            end else begin
              we    = 1'b1;
              waddr = ptr_q;
              wdata = {req_end_q[ADDR_BITS-1:0], SW'(rs_ext - len_q)};
            end
          end else if (req_end_q == seg_end) begin
            we    = 1'b1;
            waddr = ptr_q;
            wdata = {rd_begin, SW'(rs_ext - len_q)};
          end else if (count_q >= CW'(MAX_SEGMENTS)) begin
            status_d = STAT_FULL;
          end else begin
            // low part of the split stays in place
            we    = 1'b1;
            waddr = ptr_q;
            wdata = {rd_begin, SW'(start_q - rb_ext)};
            if (ptr_next_c < count_q) begin
              re      = 1'b1;
              raddr   = IW'(count_q - CW'(1));
              ptr_d   = IW'(count_q - CW'(1));
              state_d = S_SHIFT_UP;
            end else begin
              state_d = S_SPLIT;
            end
          end
        end
      end

      S_SHIFT_DN: begin
        we    = 1'b1;
        waddr = ptr_q - IW'(1);
        wdata = rdata_q;
        if (ptr_next_c < count_q) begin
          re    = 1'b1;
          raddr = ptr_q + IW'(1);
          ptr_d = ptr_q + IW'(1);
        end else begin
          count_d = count_q - CW'(1);
          state_d = S_RESP;
        end
      end

      S_SHIFT_UP: begin
        we    = 1'b1;
        waddr = ptr_q + IW'(1);
        wdata = rdata_q;
        if (CW'(ptr_q) > (CW'(hit_q) + CW'(1))) begin
          re    = 1'b1;
          raddr = ptr_q - IW'(1);
          ptr_d = ptr_q - IW'(1);
        end else begin
          state_d = S_SPLIT;
        end
      end

      S_SPLIT: begin
        we      = 1'b1;
        waddr   = hit_q + IW'(1);
        wdata   = {req_end_q[ADDR_BITS-1:0], SW'(seg_end_q - req_end_q)};
        count_d = count_q + CW'(1);
        state_d = S_RESP;
      end

      S_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_INIT;
      end
    endcase

    if (init_i) begin
      state_d = S_INIT;
    end
  end

  assign res_o.status        = status_q;
  assign res_o.free_segments = FREE_W'(count_q);

endmodule
`default_nettype wire

// File: test/testbench.sv
// self-checking testbench for the free interval carve allocator
`timescale 1ns / 1ps
module testbench import fic_pkg::*;;

  typedef enum logic {
    ROW_REQ,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    logic [16:0]      total;
    logic [15:0]      start;
    logic [16:0]      len;
    logic             typed;
    status_e          st;
    logic [4:0]       cnt;
  } stim_row_t;

  localparam int unsigned NUM_ROWS = 24;

  stim_row_t dir_rows [NUM_ROWS] = '{
    '{ROW_REQ, 17'd0,      16'd0,     17'd0,      1'b1, STAT_OK,       5'd1},
    '{ROW_REQ, 17'd0,      16'd65535, 17'd2,      1'b1, STAT_OVERRUN,  5'd1},
    '{ROW_REQ, 17'd0,      16'd65535, 17'd131071, 1'b1, STAT_OVERRUN,  5'd1},
    '{ROW_REQ, 17'd0,      16'd100,   17'd100,    1'b0, STAT_OK,       5'd0},
    '{ROW_REQ, 17'd0,      16'd0,     17'd100,    1'b0, STAT_OK,       5'd0},
    '{ROW_REQ, 17'd0,      16'd150,   17'd10,     1'b0, STAT_OK,       5'd0},
    '{ROW_REQ, 17'd0,      16'd65000, 17'd536,    1'b0, STAT_OK,       5'd0},
    '{ROW_REQ, 17'd0,      16'd200,   17'd0,      1'b0, STAT_OK,       5'd0},
    '{ROW_REQ, 17'd0,      16'd300,   17'd65236,  1'b0, STAT_OK,       5'd0},
    '{ROW_CFG, 17'd0,      16'd0,     17'd0,      1'b0, STAT_OK,       5'd0},
    '{ROW_REQ, 17'd0,      16'd0,     17'd1,      1'b1, STAT_NOT_FREE, 5'd0},
    '{ROW_REQ, 17'd0,      16'd0,     17'd0,      1'b1, STAT_NOT_FREE, 5'd0},
    '{ROW_CFG, 17'd131071, 16'd0,     17'd0,      1'b0, STAT_OK,       5'd0},
    '{ROW_REQ, 17'd0,      16'd0,     17'd65536,  1'b1, STAT_OK,       5'd0},
    '{ROW_REQ, 17'd0,      16'd65535, 17'd1,      1'b1, STAT_NOT_FREE, 5'd0},
    '{ROW_CFG, 17'd1,      16'd0,     17'd0,      1'b0, STAT_OK,       5'd0},
    '{ROW_REQ, 17'd0,      16'd1,     17'd1,      1'b1, STAT_NOT_FREE, 5'd1},
    '{ROW_REQ, 17'd0,      16'd0,     17'd2,      1'b1, STAT_OVERRUN,  5'd1},
    '{ROW_REQ, 17'd0,      16'd0,     17'd1,      1'b1, STAT_OK,       5'd0},
    '{ROW_CFG, 17'd65536,  16'd0,     17'd0,      1'b0, STAT_OK,       5'd0},
    '{ROW_REQ, 17'd0,      16'd32768, 17'd1,      1'b0, STAT_OK,       5'd0},
    '{ROW_REQ, 17'd0,      16'd43690, 17'd21845,  1'b0, STAT_OK,       5'd0},
    '{ROW_REQ, 17'd0,      16'd21845, 17'd87381,  1'b0, STAT_OK,       5'd0},
    '{ROW_REQ, 17'd0,      16'd0,     17'd32768,  1'b0, STAT_OK,       5'd0}
  };

  logic clk_i;
  logic rst_ni;

  fic_req_if req_if ();
  fic_rsp_if rsp_if ();
  fic_cfg_if cfg_if ();

  free_interval_carve u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  // shadow copy of the free segment table
  logic [ADDR_BITS_DEF-1:0] fl_begin [MAX_SEGMENTS_DEF];
  logic [ADDR_BITS_DEF:0]   fl_size  [MAX_SEGMENTS_DEF];
  logic [FREE_W-1:0]        fl_count;

  result_t     pending_results [$];
  int unsigned errors;
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  bit          small_mode;

  function automatic void table_reload(input logic [TOTAL_W-1:0] total);
    logic [TOTAL_W-1:0] sz;
    sz = (total > TOTAL_RESET) ? TOTAL_RESET : total;
    if (sz == '0) begin
      fl_count = '0;
    end else begin
      fl_begin[0] = '0;
      fl_size[0]  = sz;
      fl_count    = 5'd1;
    end
  endfunction

  function automatic status_e carve_range(input logic [START_W-1:0] start,
                                          input logic [LEN_W-1:0] len);
    int          hit;
    logic [17:0] seg_end;
    logic [17:0] req_end;
    hit = -1;
    for (int i = 0; i < fl_count; i++) begin
      if (hit < 0 && fl_begin[i] <= start &&
          {2'b00, start} < {2'b00, fl_begin[i]} + {1'b0, fl_size[i]}) begin
        hit = i;
      end
    end
    if (hit < 0) return STAT_NOT_FREE;
    seg_end = {2'b00, fl_begin[hit]} + {1'b0, fl_size[hit]};
    req_end = {2'b00, start} + {1'b0, len};
    if (req_end > seg_end) return STAT_OVERRUN;
    if (len == '0) return STAT_OK;
    if (start == fl_begin[hit]) begin
      if (len == fl_size[hit]) begin
        for (int i = hit; i + 1 < fl_count; i++) begin
          fl_begin[i] = fl_begin[i+1];
          fl_size[i]  = fl_size[i+1];
        end
        fl_count = fl_count - 5'd1;
      end else begin
        fl_begin[hit] = req_end[ADDR_BITS_DEF-1:0];
        fl_size[hit]  = fl_size[hit] - len;
      end
    end else if (req_end == seg_end) begin
      fl_size[hit] = fl_size[hit] - len;
    end else begin
      if (fl_count >= MAX_SEGMENTS_DEF) return STAT_FULL;
      for (int i = int'(fl_count); i > hit + 1; i--) begin
        fl_begin[i] = fl_begin[i-1];
        fl_size[i]  = fl_size[i-1];
      end
      fl_begin[hit+1] = req_end[ADDR_BITS_DEF-1:0];
      fl_size[hit+1]  = 17'(seg_end - req_end);
      fl_size[hit]    = {1'b0, start - fl_begin[hit]};
      fl_count        = fl_count + 5'd1;
    end
    return STAT_OK;
  endfunction

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_req(input logic [START_W-1:0] start, input logic [LEN_W-1:0] len,
                          input logic typed, input result_t typed_res);
    status_e st;
    result_t res;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.alloc_start  <= start;
    req_if.alloc_length <= len;
    do @(posedge clk_i); while (!req_if.ready);
    st = carve_range(start, len);
    res.status        = st;
    res.free_segments = fl_count;
    pending_results.push_back(typed ? typed_res : res);
  endtask

  task automatic write_total(input logic [TOTAL_W-1:0] total);
    req_if.valid <= 1'b0;
    wait_drained();
    repeat (40) @(posedge clk_i);
    cfg_if.valid      <= 1'b1;
    cfg_if.total_size <= total;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    table_reload(total);
  endtask

  task automatic pick_request(output logic [START_W-1:0] start,
                              output logic [LEN_W-1:0] len);
    int unsigned roll;
    int unsigned shape;
    int unsigned k;
    int unsigned b;
    int unsigned s;
    int unsigned cap;
    int unsigned off;
    int unsigned ln;
    int unsigned mid_w;
    roll  = $urandom_range(0, 99);
    mid_w = small_mode ? 55 : 30;
    if (fl_count != 0 && roll < 75) begin
      k   = $urandom_range(0, fl_count - 1);
      b   = 32'(fl_begin[k]);
      s   = 32'(fl_size[k]);
      cap = ($urandom_range(0, 3) == 0) ? s : ((s < 8) ? s : 8);
      shape = $urandom_range(0, 99);
      if (shape < mid_w && s >= 3) begin
        off = $urandom_range(1, s - 2);
        ln  = $urandom_range(1, (s - off - 1 < cap) ? s - off - 1 : cap);
        start = START_W'(b + off);
      end else if (shape < mid_w + 15) begin
        ln    = $urandom_range(1, cap);
        start = START_W'(b);
      end else if (shape < mid_w + 30) begin
        ln    = $urandom_range(1, cap);
        start = START_W'(b + s - ln);
      end else if (shape < mid_w + 36) begin
        ln    = s;
        start = START_W'(b);
      end else if (shape < mid_w + 40) begin
        ln    = 0;
        start = START_W'(b + $urandom_range(0, s - 1));
      end else begin
        off   = $urandom_range(0, s - 1);
        start = START_W'(b + off);
        ln    = s - off + $urandom_range(1, 300);
        if (ln > 131071) ln = 131071;
      end
      len = LEN_W'(ln);
    end else if (fl_count != 0 && roll < 88) begin
      // just past the end or just before the start of a segment
      k = $urandom_range(0, fl_count - 1);
      if ($urandom_range(0, 1) == 0) begin
        start = START_W'(fl_begin[k] + fl_size[k]);
      end else begin
        start = START_W'(fl_begin[k] - 1);
      end
      len = LEN_W'($urandom_range(1, 16));
    end else begin
      start = START_W'($urandom_range(0, 65535));
      len   = ($urandom_range(0, 1) == 0) ? LEN_W'($urandom_range(0, 131071)) :
                                            LEN_W'($urandom_range(0, 64));
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("Some tests failed");
    $finish;
  end

  // response side: random stalls and comparison against the oldest expectation
  initial begin
    result_t exp_res;
    result_t act_res;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
        act_res.status        = status_e'(rsp_if.status);
        act_res.free_segments = rsp_if.free_segments;
        if (pending_results.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected result: status=%0d free_segments=%0d",
                     act_res.status, act_res.free_segments);
          end
        end else begin
          exp_res = pending_results.pop_front();
          if (act_res.status !== exp_res.status ||
              act_res.free_segments !== exp_res.free_segments) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch: expected status=%0d count=%0d, got status=%0d count=%0d",
                       exp_res.status, exp_res.free_segments,
                       act_res.status, act_res.free_segments);
            end
          end
        end
      end
      rsp_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  initial begin
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   len;
    logic [TOTAL_W-1:0] total;
    result_t            typed_res;
    rst_ni              = 1'b0;
    req_if.valid        = 1'b0;
    req_if.alloc_start  = '0;
    req_if.alloc_length = '0;
    cfg_if.valid        = 1'b0;
    cfg_if.total_size   = '0;
    errors              = 0;
    src_idle_pct        = 38;
    snk_idle_pct        = 52;
    small_mode          = 1'b0;
    table_reload(TOTAL_RESET);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NUM_ROWS; r++) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        write_total(dir_rows[r].total);
      end else begin
        typed_res.status        = dir_rows[r].st;
        typed_res.free_segments = dir_rows[r].cnt;
        send_req(dir_rows[r].start, dir_rows[r].len, dir_rows[r].typed, typed_res);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          src_idle_pct = 38;
          snk_idle_pct = 52;
        end
        1: begin
          src_idle_pct = 52;
          snk_idle_pct = 38;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      for (int ep = 0; ep < 6; ep++) begin
        case (ep % 3)
          0: total = TOTAL_W'($urandom_range(16, 64));
          1: total = TOTAL_W'($urandom_range(0, 131071));
          default: total = ($urandom_range(0, 1) == 0) ? TOTAL_RESET :
                                                         TOTAL_W'($urandom_range(65, 4096));
        endcase
        small_mode = (total <= 64);
        write_total(total);
        for (int n = 0; n < 53; n++) begin
          if (ph == 0 && ep == 2 && n == 26) begin
            req_if.valid <= 1'b0;
            wait_drained();
          end
          pick_request(start, len);
          send_req(start, len, 1'b0, '0);
        end
      end
    end

    req_if.valid <= 1'b0;
    wait_drained();
    repeat (60) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $display("%0d results never arrived", pending_results.size());
    end
    if (errors == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
design/fic_pkg.sv
design/fic_req_if.sv
design/fic_rsp_if.sv
design/fic_cfg_if.sv
design/fic_engine.sv
design/free_interval_carve.sv
test/testbench.sv
